### sv/siphash_mac_engine_defines.svh
// Assertion helpers for the SipHash MAC engine.
// Each macro expects clk and rst_n in scope.
`ifndef SIPHASH_MAC_ENGINE_DEFINES_SVH
`define SIPHASH_MAC_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SIPH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SIPH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/siph_pkg.sv
package siph_pkg;

  localparam int unsigned LANE_W      = 64;
  localparam int unsigned BYTE_CNT_W  = 4;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned ROUND_W     = 5;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_CNT_W-1:0] BYTES_PER_WORD = 4'd8;
  localparam logic [3:0]            MAX_COMP_ROUNDS = 4'd8;
  localparam logic [ROUND_W-1:0]    MAX_FINAL_ROUNDS = 5'd16;

  localparam logic [LANE_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [LANE_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [LANE_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [LANE_W-1:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [LANE_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  typedef logic [LANE_W-1:0] word_t;
  typedef logic [3:0][LANE_W-1:0] lanes_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW      = 3'd0,
    CFG_KEY_HIGH     = 3'd1,
    CFG_COMP_ROUNDS  = 3'd2,
    CFG_FINAL_ROUNDS = 3'd3,
    CFG_EXPECTED_TAG = 3'd4
  } cfg_idx_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_FBLK,
    ST_FINAL
  } core_state_t;

  // One classified item: optional full-word absorb, then optional final block
  typedef struct packed {
    logic  start;
    logic  has_word;
    logic  fin;
    word_t word;
    word_t fblk;
  } op_t;

  // Settings the back end reads
  typedef struct packed {
    word_t              key_low;
    word_t              key_high;
    logic [3:0]         comp_rounds;
    logic [ROUND_W-1:0] final_rounds;
  } cfg_t;

  function automatic word_t rotl(input word_t x, input int unsigned s);
    return (x << s) | (x >> (LANE_W - s));
  endfunction

  // One SipRound over the four lanes
  function automatic lanes_t sip_round(input lanes_t v);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    c = c + d;
    b = rotl(b, 13);
    d = rotl(d, 16);
    b = b ^ a;
    d = d ^ c;
    a = rotl(a, 32);
    c = c + b;
    a = a + d;
    b = rotl(b, 17);
    d = rotl(d, 21);
    b = b ^ c;
    d = d ^ a;
    c = rotl(c, 32);
    return {d, c, b, a};
  endfunction

  function automatic logic [ROUND_W-1:0] comp_limit(input logic [3:0] r);
    logic [ROUND_W-1:0] n;
    if (r == '0) begin
      n = ROUND_W'(1);
    end else if (r > MAX_COMP_ROUNDS) begin
      n = ROUND_W'(MAX_COMP_ROUNDS);
    end else begin
      n = ROUND_W'(r);
    end
    return n;
  endfunction

  function automatic logic [ROUND_W-1:0] final_limit(input logic [ROUND_W-1:0] r);
    logic [ROUND_W-1:0] n;
    if (r == '0) begin
      n = ROUND_W'(1);
    end else if (r > MAX_FINAL_ROUNDS) begin
      n = MAX_FINAL_ROUNDS;
    end else begin
      n = r;
    end
    return n;
  endfunction

  // Keep the first n bytes of a word, zero the rest
  function automatic word_t keep_bytes(input word_t w, input logic [BYTE_CNT_W-1:0] n);
    word_t m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (BYTE_CNT_W'(i) < n) begin
        m[8*i +: 8] = w[8*i +: 8];
      end
    end
    return m;
  endfunction

endpackage

### sv/siph_fifo.sv
module siph_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  siph_pkg::op_t  wdata,
  input  logic           pop,
  output siph_pkg::op_t  rdata,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PTR_W = (siph_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(siph_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(siph_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(siph_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(siph_pkg::QUEUE_DEPTH);

  siph_pkg::op_t    mem [siph_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == DEPTH_CNT);
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/siph_front.sv
module siph_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [siph_pkg::LANE_W-1:0]         in_message_word,
  input  logic [siph_pkg::BYTE_CNT_W-1:0]     in_byte_count,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                q_push,
  output siph_pkg::op_t                       q_wdata
);

  logic                                in_msg_r, in_msg_nxt;
  logic [siph_pkg::LEN_W-1:0]          len_r, len_nxt;
  logic [siph_pkg::LEN_W-1:0]          len_base;
  logic [siph_pkg::LEN_W-1:0]          len_new;
  logic [siph_pkg::BYTE_CNT_W-1:0]     cnt_sat;
  logic                                full_word;
  logic                                accept;
  siph_pkg::word_t                     len_blk;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // Classify the item and build the final block
  always_comb begin
    len_base  = in_msg_r ? len_r : '0;
    cnt_sat   = (in_byte_count > siph_pkg::BYTES_PER_WORD) ?
                siph_pkg::BYTES_PER_WORD : in_byte_count;
    full_word = !in_last || (cnt_sat == siph_pkg::BYTES_PER_WORD);
    len_new   = len_base + (full_word ? siph_pkg::LEN_W'(siph_pkg::BYTES_PER_WORD)
                                      : siph_pkg::LEN_W'(cnt_sat));
    len_blk   = {len_new, {(siph_pkg::LANE_W - siph_pkg::LEN_W){1'b0}}};

    q_wdata.start    = !in_msg_r;
    q_wdata.has_word = full_word;
    q_wdata.fin      = in_last;
    q_wdata.word     = in_message_word;
    q_wdata.fblk     = full_word ? len_blk
                                 : (siph_pkg::keep_bytes(in_message_word, cnt_sat) | len_blk);
  end

  // Track message boundary and running length
  always_comb begin
    in_msg_nxt = in_msg_r;
    len_nxt    = len_r;
    if (accept) begin
      in_msg_nxt = !in_last;
      len_nxt    = in_last ? '0 : len_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      len_r    <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

### sv/siph_core.sv
module siph_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  siph_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  siph_pkg::op_t                q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [siph_pkg::LANE_W-1:0]  out_tag
);

  siph_pkg::core_state_t          state_r, state_nxt;
  siph_pkg::lanes_t               lanes_r, lanes_nxt;
  siph_pkg::word_t                px_r, px_nxt;
  siph_pkg::word_t                fblk_r, fblk_nxt;
  logic                           fin_r, fin_nxt;
  logic [siph_pkg::ROUND_W-1:0]   cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  siph_pkg::word_t                out_tag_r, out_tag_nxt;

  logic [siph_pkg::ROUND_W-1:0]   n_comp;
  logic [siph_pkg::ROUND_W-1:0]   n_fin;
  logic [siph_pkg::ROUND_W-1:0]   phase_n;
  logic                           phase_done;
  logic                           out_free;
  logic                           want_pop;
  logic                           do_round;
  logic                           out_load;
  siph_pkg::lanes_t               key_init;
  siph_pkg::lanes_t               cont;
  siph_pkg::lanes_t               rin;

  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;

  // Next state, round input select and queue pop
  always_comb begin
    n_comp     = siph_pkg::comp_limit(cfg.comp_rounds);
    n_fin      = siph_pkg::final_limit(cfg.final_rounds);
    phase_n    = (state_r == siph_pkg::ST_FINAL) ? n_fin : n_comp;
    phase_done = (cnt_r >= phase_n);
    out_free   = !out_valid_r || out_ready;

    key_init[0] = cfg.key_low  ^ siph_pkg::SIP_C0;
    key_init[1] = cfg.key_high ^ siph_pkg::SIP_C1;
    key_init[2] = cfg.key_low  ^ siph_pkg::SIP_C2;
    key_init[3] = cfg.key_high ^ siph_pkg::SIP_C3;

    // Lanes with the pending lane-0 xor of the last absorb applied
    cont    = lanes_r;
    cont[0] = lanes_r[0] ^ px_r;

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    px_nxt    = px_r;
    fin_nxt   = fin_r;
    fblk_nxt  = fblk_r;
    rin       = lanes_r;
    do_round  = 1'b0;
    want_pop  = 1'b0;
    out_load  = 1'b0;
    q_pop     = 1'b0;

    case (state_r)
      siph_pkg::ST_IDLE: begin
        want_pop = !q_empty;
      end
      siph_pkg::ST_WORD: begin
        if (!phase_done) begin
          do_round = 1'b1;
          cnt_nxt  = cnt_r + siph_pkg::ROUND_W'(1);
        end else if (fin_r) begin
          // start the final block
          rin       = cont;
          rin[3]    = lanes_r[3] ^ fblk_r;
          px_nxt    = fblk_r;
          do_round  = 1'b1;
          cnt_nxt   = siph_pkg::ROUND_W'(1);
          state_nxt = siph_pkg::ST_FBLK;
        end else begin
          want_pop = !q_empty;
          if (q_empty) begin
            state_nxt = siph_pkg::ST_IDLE;
          end
        end
      end
      siph_pkg::ST_FBLK: begin
        if (!phase_done) begin
          do_round = 1'b1;
          cnt_nxt  = cnt_r + siph_pkg::ROUND_W'(1);
        end else begin
          // start finalization
          rin       = cont;
          rin[2]    = lanes_r[2] ^ siph_pkg::FINAL_XOR;
          px_nxt    = '0;
          do_round  = 1'b1;
          cnt_nxt   = siph_pkg::ROUND_W'(1);
          state_nxt = siph_pkg::ST_FINAL;
        end
      end
      siph_pkg::ST_FINAL: begin
        if (!phase_done) begin
          do_round = 1'b1;
          cnt_nxt  = cnt_r + siph_pkg::ROUND_W'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          want_pop = !q_empty;
          if (q_empty) begin
            state_nxt = siph_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = siph_pkg::ST_IDLE;
      end
    endcase

    // Begin the next queued item
    if (want_pop) begin
      q_pop    = 1'b1;
      rin      = q_rdata.start ? key_init : cont;
      fin_nxt  = q_rdata.fin;
      fblk_nxt = q_rdata.fblk;
      do_round = 1'b1;
      cnt_nxt  = siph_pkg::ROUND_W'(1);
      if (q_rdata.has_word) begin
        rin[3]    = rin[3] ^ q_rdata.word;
        px_nxt    = q_rdata.word;
        state_nxt = siph_pkg::ST_WORD;
      end else begin
        rin[3]    = rin[3] ^ q_rdata.fblk;
        px_nxt    = q_rdata.fblk;
        state_nxt = siph_pkg::ST_FBLK;
      end
    end

    lanes_nxt = do_round ? siph_pkg::sip_round(rin) : lanes_r;

    // Output register
    out_valid_nxt = out_valid_r && !out_ready;
    out_tag_nxt   = out_tag_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_tag_nxt   = lanes_r[0] ^ lanes_r[1] ^ lanes_r[2] ^ lanes_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= siph_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lanes_r   <= lanes_nxt;
    px_r      <= px_nxt;
    fin_r     <= fin_nxt;
    fblk_r    <= fblk_nxt;
    out_tag_r <= out_tag_nxt;
  end

endmodule

### sv/siphash_mac_engine.sv
// Keyed SipHash MAC engine. Message words enter with their valid-byte count and a last flag;
// each final word yields one 64-bit tag plus a flag that is set when the tag equals the
// programmed expected tag. A front end tracks message start and byte length, builds the
// padded final block and posts one item per word into a two-entry queue; the back end runs
// one SipRound per cycle in a single round unit. A word that is not last gets
// compression_rounds SipRounds (2 for SipHash-2-4), and the next queued word starts as soon
// as those finish. A last word gets compression_rounds SipRounds for the final block, plus
// another compression_rounds when it carries eight bytes, plus final_rounds rounds, and the
// tag is then formed. The front end keeps accepting words while the queue has room,
// and a finished tag waits in its own output register. Round settings are clamped to 1..8
// and 1..16; configuration writes are always accepted, but the back end reads the registers
// as it works, so write them only while no message is in flight.
`include "siphash_mac_engine_defines.svh"

module siphash_mac_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [siph_pkg::LANE_W-1:0]         in_message_word,
  input  logic [siph_pkg::BYTE_CNT_W-1:0]     in_byte_count,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [siph_pkg::LANE_W-1:0]         out_tag,
  output logic                                out_match,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [siph_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [siph_pkg::LANE_W-1:0]         cfg_data
);

  siph_pkg::word_t                key_low_r, key_low_nxt;
  siph_pkg::word_t                key_high_r, key_high_nxt;
  logic [3:0]                     comp_rounds_r, comp_rounds_nxt;
  logic [siph_pkg::ROUND_W-1:0]   final_rounds_r, final_rounds_nxt;
  siph_pkg::word_t                exp_tag_r, exp_tag_nxt;
  siph_pkg::cfg_t                 cfg;

  logic                           q_push;
  logic                           q_pop;
  logic                           q_full;
  logic                           q_empty;
  siph_pkg::op_t                  q_wdata;
  siph_pkg::op_t                  q_rdata;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    key_low_nxt      = key_low_r;
    key_high_nxt     = key_high_r;
    comp_rounds_nxt  = comp_rounds_r;
    final_rounds_nxt = final_rounds_r;
    exp_tag_nxt      = exp_tag_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        siph_pkg::CFG_KEY_LOW:      key_low_nxt      = cfg_data;
        siph_pkg::CFG_KEY_HIGH:     key_high_nxt     = cfg_data;
        siph_pkg::CFG_COMP_ROUNDS:  comp_rounds_nxt  = cfg_data[3:0];
        siph_pkg::CFG_FINAL_ROUNDS: final_rounds_nxt = cfg_data[siph_pkg::ROUND_W-1:0];
        siph_pkg::CFG_EXPECTED_TAG: exp_tag_nxt      = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r      <= '0;
      key_high_r     <= '0;
      comp_rounds_r  <= 4'd2;
      final_rounds_r <= 5'd4;
      exp_tag_r      <= '0;
    end else begin
      key_low_r      <= key_low_nxt;
      key_high_r     <= key_high_nxt;
      comp_rounds_r  <= comp_rounds_nxt;
      final_rounds_r <= final_rounds_nxt;
      exp_tag_r      <= exp_tag_nxt;
    end
  end

  always_comb begin
    cfg.key_low      = key_low_r;
    cfg.key_high     = key_high_r;
    cfg.comp_rounds  = comp_rounds_r;
    cfg.final_rounds = final_rounds_r;
  end

  siph_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message_word (in_message_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  siph_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  siph_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tag   (out_tag)
  );

  // Compare against the expected tag
  assign out_match = (out_tag == exp_tag_r);

  `SIPH_ASSERT_IMPL(a_no_push_full, q_push, !q_full, "queue written while full")
  `SIPH_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_empty, "queue read while empty")
  `SIPH_ASSERT_IMPL(a_fin_kept, in_valid && in_ready, q_push && (q_wdata.fin == in_last), "item lost")
  `SIPH_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_tag), "tag not held")

endmodule
